// ===== hdl/lobm_pkg.sv =====
// Shared types and constants of the order book matcher.
// Depends on nothing; used by the matcher, its arithmetic unit and its checker.
package lobm_pkg;

    localparam int TOTAL_BITS  = 26;
    localparam int MAKER_BITS  = 11;
    localparam int OUT_QTY_BITS = 16;

    typedef enum logic [1:0] {
        ST_OPEN     = 2'd0,
        ST_PARTIAL  = 2'd1,
        ST_FILLED   = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD  = 1'b0,
        ALU_FILL = 1'b1
    } alu_op_t;

endpackage

// ===== hdl/limit_order_book_matcher.sv =====
// Limit order book matcher, price-time priority, one order per command.
// Rate and use:
//   Raise start with one order while busy is low; the order is taken at
//   that edge and busy stays high until its result is out. The result
//   shows for exactly one cycle with done high; it cannot be held off.
//   A limit order rests at the tail of its level queue: the level is
//   read, then updated, then the old tail is linked when the level
//   already holds orders. A market order sweeps the opposite side from
//   the best price, one resting order at a time, and when a level empties
//   the next best is searched one level at a time through the level
//   memory read port. Each touched maker is a read-modify-write of the
//   order store through the shared quantity unit.
//   After reset the block clears the level memory and refills the free
//   slot stack, one entry a cycle; busy stays high during that sweep.
// Depends on lobm_pkg, lobm_ram and lobm_alu.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int NUM_PRICE_LEVELS   = 1024,
    parameter int MAX_RESTING_ORDERS = 1024,
    parameter int QTY_BITS           = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic        side,
    input  logic [31:0] order_id,
    input  logic [9:0]  price_tick,
    input  logic [15:0] quantity,
    output logic        done,
    output logic [31:0] order_id_echo,
    output logic [1:0]  status,
    output logic [15:0] filled_quantity,
    output logic [15:0] unfilled_quantity,
    output logic [10:0] makers_removed,
    output logic [25:0] level_total
);

    localparam int QB   = (QTY_BITS < OUT_QTY_BITS) ? QTY_BITS : OUT_QTY_BITS;
    localparam int SB   = $clog2(MAX_RESTING_ORDERS);
    localparam int CB   = $clog2(MAX_RESTING_ORDERS + 1);
    localparam int PB   = $clog2(NUM_PRICE_LEVELS);
    localparam int LD   = 2 * NUM_PRICE_LEVELS;
    localparam int LB   = $clog2(LD);
    localparam int TB   = TOTAL_BITS;
    localparam int LW   = 1 + 2 * SB + TB;
    localparam int CLRN = (LD > MAX_RESTING_ORDERS) ? LD : MAX_RESTING_ORDERS;
    localparam int CLB  = $clog2(CLRN);
    localparam logic [31:0] NPL_W = 32'(NUM_PRICE_LEVELS);
    localparam logic [PB-1:0] PMAX = PB'(NUM_PRICE_LEVELS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LRD,
        S_LUPD,
        S_LLINK,
        S_MBEST,
        S_MLVL,
        S_MFILL,
        S_SCAN_RD,
        S_SCAN_CK
    } state_t;

    function automatic logic [LB-1:0] lv_of(input logic sd, input logic [PB-1:0] p);
        lv_of = sd ? (LB'(NUM_PRICE_LEVELS) + LB'(p)) : LB'(p);
    endfunction

    state_t              state_reg;
    logic [CLB-1:0]      clr_ptr_reg;
    logic                side_reg;
    logic [31:0]         id_reg;
    logic [PB-1:0]       price_reg;
    logic [QB-1:0]       qty_reg;
    logic [QB-1:0]       rem_reg;
    logic [QB-1:0]       filled_reg;
    logic [MAKER_BITS-1:0] makers_reg;
    logic [LW-1:0]       lvl_reg;
    logic [SB-1:0]       slot_reg;
    logic [SB-1:0]       tail_reg;
    logic [CB-1:0]       free_count_reg;
    logic [PB-1:0]       best_price_reg [2];
    logic                best_valid_reg [2];
    logic [PB-1:0]       scan_ptr_reg;
    logic                done_reg;
    logic [1:0]          status_reg;
    logic [15:0]         filled_out_reg;
    logic [15:0]         unfilled_out_reg;
    logic [25:0]         total_out_reg;

    // memory ports
    logic            lvl_we;
    logic [LB-1:0]   lvl_waddr;
    logic [LW-1:0]   lvl_wdata;
    logic [LB-1:0]   lvl_raddr;
    logic [LW-1:0]   lvl_rdata;
    logic            free_we;
    logic [SB-1:0]   free_waddr;
    logic [SB-1:0]   free_wdata;
    logic [SB-1:0]   free_raddr;
    logic [SB-1:0]   free_rdata;
    logic            qty_we;
    logic [SB-1:0]   qty_waddr;
    logic [QB-1:0]   qty_wdata;
    logic [QB-1:0]   qty_rdata;
    logic            link_we;
    logic [SB-1:0]   link_waddr;
    logic [SB-1:0]   link_wdata;
    logic [SB-1:0]   link_rdata;
    logic [SB-1:0]   rd_head;

    // shared unit ports
    alu_op_t         alu_op;
    logic [QB-1:0]   alu_taker;
    logic [QB-1:0]   alu_maker;
    logic [TB-1:0]   alu_total_in;
    logic [QB-1:0]   alu_fill;
    logic [QB-1:0]   alu_maker_left;
    logic [QB-1:0]   alu_taker_left;
    logic [QB-1:0]   alu_filled;
    logic [TB-1:0]   alu_total;

    logic            opp;
    logic [LB-1:0]   lv_in;
    logic [31:0]     price_w;
    logic [PB-1:0]   price_sat;

    // level word fields
    logic            rd_valid;
    logic [SB-1:0]   rd_tail;
    logic [TB-1:0]   rd_total;
    logic            q_valid;
    logic [SB-1:0]   q_head;
    logic [SB-1:0]   q_tail;
    logic [TB-1:0]   q_total;

    assign rd_valid = lvl_rdata[LW-1];
    assign rd_head  = lvl_rdata[TB+2*SB-1:TB+SB];
    assign rd_tail  = lvl_rdata[TB+SB-1:TB];
    assign rd_total = lvl_rdata[TB-1:0];
    assign q_valid  = lvl_reg[LW-1];
    assign q_head   = lvl_reg[TB+2*SB-1:TB+SB];
    assign q_tail   = lvl_reg[TB+SB-1:TB];
    assign q_total  = lvl_reg[TB-1:0];

    assign opp     = ~side_reg;
    assign lv_in   = lv_of(side_reg, price_reg);
    assign price_w = {22'd0, price_tick};
    assign price_sat = (price_w >= NPL_W) ? PMAX : price_w[PB-1:0];

    lobm_ram #(.WIDTH(LW), .DEPTH(LD)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    lobm_ram #(.WIDTH(SB), .DEPTH(MAX_RESTING_ORDERS)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    lobm_ram #(.WIDTH(QB), .DEPTH(MAX_RESTING_ORDERS)) u_qty_ram (
        .clk   (clk),
        .we    (qty_we),
        .waddr (qty_waddr),
        .wdata (qty_wdata),
        .raddr (rd_head),
        .rdata (qty_rdata)
    );

    lobm_ram #(.WIDTH(SB), .DEPTH(MAX_RESTING_ORDERS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_head),
        .rdata (link_rdata)
    );

    lobm_alu #(.QB(QB)) u_alu (
        .op         (alu_op),
        .taker_qty  (alu_taker),
        .maker_qty  (alu_maker),
        .filled_in  (filled_reg),
        .total_in   (alu_total_in),
        .fill_qty   (alu_fill),
        .maker_left (alu_maker_left),
        .taker_left (alu_taker_left),
        .filled_out (alu_filled),
        .total_out  (alu_total)
    );

    // drive memory ports and the shared unit from the sequencer state
    always_comb
    begin
        lvl_we     = 1'b0;
        lvl_waddr  = lv_in;
        lvl_wdata  = '0;
        lvl_raddr  = lv_in;
        free_we    = 1'b0;
        free_waddr = free_count_reg[SB-1:0];
        free_wdata = q_head;
        free_raddr = SB'(free_count_reg - CB'(1));
        qty_we     = 1'b0;
        qty_waddr  = free_rdata;
        qty_wdata  = qty_reg;
        link_we    = 1'b0;
        link_waddr = free_rdata;
        link_wdata = '0;
        alu_op       = ALU_ADD;
        alu_taker    = qty_reg;
        alu_maker    = qty_rdata;
        alu_total_in = rd_total;
        unique case (state_reg)
            S_CLEAR:
            begin
                lvl_we    = (32'(clr_ptr_reg) < 32'(LD));
                lvl_waddr = LB'(clr_ptr_reg);
                free_we    = (32'(clr_ptr_reg) < 32'(MAX_RESTING_ORDERS));
                free_waddr = SB'(clr_ptr_reg);
                free_wdata = SB'(clr_ptr_reg);
            end
            S_LUPD:
            begin
                // rest the order at the tail of its level
                if (qty_reg != '0 && free_count_reg != '0)
                begin
                    qty_we    = 1'b1;
                    link_we   = 1'b1;
                    lvl_we    = 1'b1;
                    lvl_wdata = {1'b1, (rd_valid ? rd_head : free_rdata), free_rdata, alu_total};
                end
            end
            S_LLINK:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
            end
            S_MBEST:
            begin
                lvl_raddr = lv_of(opp, best_price_reg[opp]);
            end
            S_MFILL:
            begin
                // fill the head maker and update its level
                alu_op       = ALU_FILL;
                alu_taker    = rem_reg;
                alu_total_in = q_total;
                qty_we       = 1'b1;
                qty_waddr    = q_head;
                qty_wdata    = alu_maker_left;
                lvl_we       = 1'b1;
                lvl_waddr    = lv_of(opp, best_price_reg[opp]);
                if (alu_maker_left == '0)
                begin
                    free_we = (32'(free_count_reg) < 32'(MAX_RESTING_ORDERS));
                    if (q_head == q_tail)
                    begin
                        lvl_wdata = '0;
                    end
                    else
                    begin
                        lvl_wdata = {1'b1, link_rdata, q_tail, alu_total};
                    end
                end
                else
                begin
                    lvl_wdata = {q_valid, q_head, q_tail, alu_total};
                end
            end
            S_SCAN_RD:
            begin
                lvl_raddr = lv_of(opp, scan_ptr_reg);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer: state, order registers and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_ptr_reg       <= '0;
            free_count_reg    <= CB'(MAX_RESTING_ORDERS);
            best_price_reg[0] <= '0;
            best_price_reg[1] <= '0;
            best_valid_reg[0] <= 1'b0;
            best_valid_reg[1] <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + CLB'(1);
                    if (32'(clr_ptr_reg) == CLRN - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    // take the order beat
                    if (start)
                    begin
                        side_reg   <= side;
                        id_reg     <= order_id;
                        price_reg  <= price_sat;
                        qty_reg    <= quantity[QB-1:0];
                        rem_reg    <= quantity[QB-1:0];
                        filled_reg <= '0;
                        makers_reg <= '0;
                        state_reg  <= kind ? S_MBEST : S_LRD;
                    end
                end
                S_LRD:
                begin
                    state_reg <= S_LUPD;
                end
                S_LUPD:
                begin
                    filled_out_reg <= '0;
                    total_out_reg  <= rd_total;
                    if (qty_reg == '0)
                    begin
                        status_reg       <= ST_FILLED;
                        unfilled_out_reg <= '0;
                        done_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else if (free_count_reg == '0)
                    begin
                        status_reg       <= ST_REJECTED;
                        unfilled_out_reg <= 16'(qty_reg);
                        done_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        status_reg       <= ST_OPEN;
                        unfilled_out_reg <= 16'(qty_reg);
                        total_out_reg    <= alu_total;
                        free_count_reg   <= free_count_reg - CB'(1);
                        slot_reg         <= free_rdata;
                        tail_reg         <= rd_tail;
                        if (!best_valid_reg[side_reg] ||
                            (side_reg ? (price_reg < best_price_reg[side_reg])
                                      : (price_reg > best_price_reg[side_reg])))
                        begin
                            best_price_reg[side_reg] <= price_reg;
                            best_valid_reg[side_reg] <= 1'b1;
                        end
                        if (rd_valid)
                        begin
                            state_reg <= S_LLINK;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_LLINK:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_MBEST:
                begin
                    if (rem_reg == '0 || !best_valid_reg[opp])
                    begin
                        status_reg       <= (rem_reg == '0) ? ST_FILLED : ST_PARTIAL;
                        filled_out_reg   <= 16'(filled_reg);
                        unfilled_out_reg <= 16'(rem_reg);
                        total_out_reg    <= '0;
                        done_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_MLVL;
                    end
                end
                S_MLVL:
                begin
                    lvl_reg   <= lvl_rdata;
                    state_reg <= S_MFILL;
                end
                S_MFILL:
                begin
                    rem_reg    <= alu_taker_left;
                    filled_reg <= alu_filled;
                    state_reg  <= S_MBEST;
                    if (alu_maker_left == '0)
                    begin
                        makers_reg <= makers_reg + MAKER_BITS'(1);
                        if (32'(free_count_reg) < 32'(MAX_RESTING_ORDERS))
                        begin
                            free_count_reg <= free_count_reg + CB'(1);
                        end
                        // level emptied: search for the next best price
                        if (q_head == q_tail)
                        begin
                            if (opp ? (best_price_reg[opp] == PMAX)
                                    : (best_price_reg[opp] == '0))
                            begin
                                best_valid_reg[opp] <= 1'b0;
                            end
                            else
                            begin
                                scan_ptr_reg <= opp ? (best_price_reg[opp] + PB'(1))
                                                    : (best_price_reg[opp] - PB'(1));
                                state_reg    <= S_SCAN_RD;
                            end
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CK;
                end
                S_SCAN_CK:
                begin
                    if (rd_valid)
                    begin
                        best_price_reg[opp] <= scan_ptr_reg;
                        state_reg           <= S_MBEST;
                    end
                    else if (opp ? (scan_ptr_reg == PMAX) : (scan_ptr_reg == '0))
                    begin
                        best_valid_reg[opp] <= 1'b0;
                        state_reg           <= S_MBEST;
                    end
                    else
                    begin
                        scan_ptr_reg <= opp ? (scan_ptr_reg + PB'(1)) : (scan_ptr_reg - PB'(1));
                        state_reg    <= S_SCAN_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign order_id_echo     = id_reg;
    assign status            = status_reg;
    assign filled_quantity   = filled_out_reg;
    assign unfilled_quantity = unfilled_out_reg;
    assign makers_removed    = makers_reg;
    assign level_total       = total_out_reg;

endmodule

// ===== hdl/lobm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/lobm_alu.sv =====
// Shared quantity unit: saturating level add, and one maker fill step.
// Depends on lobm_pkg.
module lobm_alu
    import lobm_pkg::*;
#(
    parameter int QB = 16
) (
    input  alu_op_t               op,
    input  logic [QB-1:0]         taker_qty,
    input  logic [QB-1:0]         maker_qty,
    input  logic [QB-1:0]         filled_in,
    input  logic [TOTAL_BITS-1:0] total_in,
    output logic [QB-1:0]         fill_qty,
    output logic [QB-1:0]         maker_left,
    output logic [QB-1:0]         taker_left,
    output logic [QB-1:0]         filled_out,
    output logic [TOTAL_BITS-1:0] total_out
);

    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] fill_w;

    always_comb
    begin
        // fill amount is the smaller of the two quantities
        fill_qty   = (taker_qty < maker_qty) ? taker_qty : maker_qty;
        maker_left = maker_qty - fill_qty;
        taker_left = taker_qty - fill_qty;
        filled_out = filled_in + fill_qty;
        fill_w     = TOTAL_BITS'(fill_qty);
        sum        = {1'b0, total_in} + (TOTAL_BITS+1)'(taker_qty);
        unique case (op)
            ALU_ADD:
            begin
                // saturate at the top of the total range
                total_out = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
            end
            ALU_FILL:
            begin
                // stop at zero
                total_out = (total_in >= fill_w) ? (total_in - fill_w) : '0;
            end
            default:
            begin
                total_out = total_in;
            end
        endcase
    end

endmodule

// ===== hdl/lobm_checker.sv =====
// Port-level checks of the order book matcher, bound to its top level.
// Depends on lobm_pkg and limit_order_book_matcher.
module lobm_checker
    import lobm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [15:0] filled_quantity,
    input logic [15:0] unfilled_quantity,
    input logic [10:0] makers_removed,
    input logic [25:0] level_total
);

    // an accepted order keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("order accepted but block not busy");

    // a result beat only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a busy cycle");

    // a filled order leaves nothing unfilled
    a_filled_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FILLED) |-> (unfilled_quantity == 16'd0))
        else $error("filled status with unfilled quantity");

    // a resting order matched nothing and its level holds quantity
    a_open_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OPEN) |->
            (filled_quantity == 16'd0 && makers_removed == 11'd0 && level_total != 26'd0))
        else $error("resting order result inconsistent");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the limit order book matcher.
// Depends on lobm_pkg and limit_order_book_matcher; keeps its own book model.
module tb_top;
    import lobm_pkg::*;

    localparam int LEVELS   = 1024;
    localparam int SLOTS    = 1024;
    localparam int TOT_MAX  = 26'h3FF_FFFF;
    localparam int CYC_MAX  = 3000000;
    localparam logic KIND_LIMIT  = 1'b0;
    localparam logic KIND_MARKET = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;

    typedef struct {
        logic        kind;
        logic        side;
        logic [31:0] id;
        logic [9:0]  px;
        logic [15:0] qty;
        int unsigned idle_pct;
    } order_t;

    typedef struct {
        logic [31:0] id;
        status_t     st;
        logic [15:0] filled;
        logic [15:0] unfilled;
        logic [10:0] makers;
        logic [25:0] total;
    } fill_rpt_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic        side;
    logic [31:0] order_id;
    logic [9:0]  price_tick;
    logic [15:0] quantity;
    logic        done;
    logic [31:0] order_id_echo;
    logic [1:0]  status;
    logic [15:0] filled_quantity;
    logic [15:0] unfilled_quantity;
    logic [10:0] makers_removed;
    logic [25:0] level_total;

    limit_order_book_matcher u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .side(side), .order_id(order_id),
        .price_tick(price_tick), .quantity(quantity), .done(done),
        .order_id_echo(order_id_echo), .status(status),
        .filled_quantity(filled_quantity), .unfilled_quantity(unfilled_quantity),
        .makers_removed(makers_removed), .level_total(level_total)
    );

    // Book model: order store, free slot stack, level queues and best prices
    int unsigned slot_qty [SLOTS];
    logic [31:0] slot_id [SLOTS];
    int unsigned slot_next [SLOTS];
    int unsigned free_stack [SLOTS];
    int unsigned free_n;
    int unsigned lvl_head [2*LEVELS];
    int unsigned lvl_tail [2*LEVELS];
    bit          lvl_on [2*LEVELS];
    int unsigned lvl_sum [2*LEVELS];
    int unsigned best_px [2];
    bit          best_on [2];

    order_t    pending_orders[$];
    fill_rpt_t expected_fills[$];
    order_t    cur;
    int unsigned n_mismatch, n_fills, n_limits, n_markets, n_rejects, n_cycles;

    always #4 clk = ~clk;

    // Append one order to the stimulus queue
    function automatic void add_order(order_t o);
        pending_orders = {pending_orders, o};
    endfunction

    // Find the best nonempty level of one side: highest bid, lowest ask
    function automatic void find_best(int unsigned sd);
        best_on[sd] = 0;
        best_px[sd] = 0;
        for (int p = 0; p < LEVELS; p++)
        begin
            if (lvl_on[sd*LEVELS + p])
            begin
                best_px[sd] = p;
                best_on[sd] = 1;
                if (sd == SIDE_SELL)
                    return;
            end
        end
    endfunction

    // Apply one order to the book and return the report it should produce
    function automatic fill_rpt_t book_apply(order_t o);
        fill_rpt_t   r;
        int unsigned lv, slot, rem, f, opp, filled, makers;
        r.id = o.id;
        r.filled = 0;
        r.unfilled = 0;
        r.makers = 0;
        r.total = 0;
        if (o.kind == KIND_LIMIT)
        begin
            lv = o.side*LEVELS + o.px;
            if (o.qty == 0)
                r.st = ST_FILLED;
            else if (free_n == 0)
            begin
                r.st = ST_REJECTED;
                r.unfilled = o.qty;
                n_rejects++;
            end
            else
            begin
                free_n--;
                slot = free_stack[free_n];
                slot_qty[slot] = o.qty;
                slot_id[slot] = o.id;
                slot_next[slot] = 0;
                if (lvl_on[lv])
                begin
                    slot_next[lvl_tail[lv]] = slot;
                    lvl_tail[lv] = slot;
                end
                else
                begin
                    lvl_head[lv] = slot;
                    lvl_tail[lv] = slot;
                    lvl_on[lv] = 1;
                end
                lvl_sum[lv] += o.qty;
                if (lvl_sum[lv] > TOT_MAX)
                    lvl_sum[lv] = TOT_MAX;
                if (!best_on[o.side] || (o.side == SIDE_BUY ? o.px > best_px[o.side]
                                                           : o.px < best_px[o.side]))
                begin
                    best_px[o.side] = o.px;
                    best_on[o.side] = 1;
                end
                r.st = ST_OPEN;
                r.unfilled = o.qty;
            end
            r.total = 26'(lvl_sum[lv]);
        end
        else
        begin
            opp = o.side ^ 1;
            rem = o.qty;
            filled = 0;
            makers = 0;
            while (rem > 0 && best_on[opp])
            begin
                lv = opp*LEVELS + best_px[opp];
                slot = lvl_head[lv];
                f = (rem < slot_qty[slot]) ? rem : slot_qty[slot];
                slot_qty[slot] -= f;
                rem -= f;
                filled += f;
                lvl_sum[lv] = (lvl_sum[lv] >= f) ? lvl_sum[lv] - f : 0;
                if (slot_qty[slot] == 0)
                begin
                    makers++;
                    if (free_n < SLOTS)
                    begin
                        free_stack[free_n] = slot;
                        free_n++;
                    end
                    if (slot == lvl_tail[lv])
                    begin
                        lvl_on[lv] = 0;
                        lvl_sum[lv] = 0;
                        find_best(opp);
                    end
                    else
                        lvl_head[lv] = slot_next[slot];
                end
            end
            r.filled = 16'(filled);
            r.unfilled = 16'(rem);
            r.makers = 11'(makers);
            r.st = (rem == 0) ? ST_FILLED : ST_PARTIAL;
        end
        return r;
    endfunction

    function automatic order_t mk_order(logic k, logic s, logic [9:0] p, logic [15:0] q,
                                        int unsigned idle);
        order_t o;
        o.kind = k;
        o.side = s;
        o.id = $urandom;
        o.px = p;
        o.qty = q;
        o.idle_pct = idle;
        return o;
    endfunction

    // Random order: mostly small sizes near the middle of the book
    function automatic order_t rand_order(int unsigned idle);
        logic [9:0]  p;
        logic [15:0] q;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            p = 10'($urandom);
        else
            p = 10'(500 + $urandom_range(15));
        r = $urandom_range(99);
        if (r < 4)
            q = 0;
        else if (r < 10)
            q = 16'($urandom);
        else
            q = 16'($urandom_range(1, 300));
        return mk_order($urandom_range(99) < 55 ? KIND_LIMIT : KIND_MARKET,
                        1'($urandom_range(1)), p, q, idle);
    endfunction

    // Drive orders; retire the one taken at this edge into the model first
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= 1'b0;
            side <= 1'b0;
            order_id <= '0;
            price_tick <= '0;
            quantity <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_fills = {expected_fills, book_apply(cur)};
                if (cur.kind == KIND_LIMIT)
                    n_limits++;
                else
                    n_markets++;
            end
            if (!start || !busy)
            begin
                if (pending_orders.size() > 0 &&
                    $urandom_range(99) >= pending_orders[0].idle_pct)
                begin
                    cur = pending_orders.pop_front();
                    kind <= cur.kind;
                    side <= cur.side;
                    order_id <= cur.id;
                    price_tick <= cur.px;
                    quantity <= cur.qty;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        fill_rpt_t e;
        if (rst_n && done)
        begin
            n_fills++;
            if (expected_fills.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result beat, id %h", order_id_echo);
            end
            else
            begin
                e = expected_fills.pop_front();
                if (order_id_echo !== e.id || status !== e.st ||
                    filled_quantity !== e.filled || unfilled_quantity !== e.unfilled ||
                    makers_removed !== e.makers || level_total !== e.total)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $display("mismatch: exp id %h st %0d fill %0d left %0d mk %0d tot %0d",
                                 e.id, e.st, e.filled, e.unfilled, e.makers, e.total);
                        $display("          got id %h st %0d fill %0d left %0d mk %0d tot %0d",
                                 order_id_echo, status, filled_quantity,
                                 unfilled_quantity, makers_removed, level_total);
                    end
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYC_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_idle [4] = '{0, 77, 0, 11};
        clk = 0;
        rst_n = 0;
        n_mismatch = 0;
        n_fills = 0;
        n_limits = 0;
        n_markets = 0;
        n_rejects = 0;
        n_cycles = 0;
        free_n = SLOTS;
        for (int i = 0; i < SLOTS; i++)
            free_stack[i] = i;
        for (int i = 0; i < 2*LEVELS; i++)
        begin
            lvl_on[i] = 0;
            lvl_sum[i] = 0;
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
        end
        best_on = '{0, 0};
        best_px = '{0, 0};

        // Directed: empty book, zero sizes, price extremes, queue order, sweeps
        add_order(mk_order(KIND_MARKET, SIDE_BUY, 10'd5, 16'd10, 0));
        add_order(mk_order(KIND_MARKET, SIDE_SELL, 10'd0, 16'd0, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_BUY, 10'd7, 16'd0, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_BUY, 10'd0, 16'd1, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_BUY, 10'd1023, 16'hFFFF, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_BUY, 10'd1023, 16'h8000, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_SELL, 10'd1023, 16'd50, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_SELL, 10'd0, 16'h5555, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_SELL, 10'd0, 16'h2AAA, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_SELL, 10'h2AA, 16'd7, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_SELL, 10'h155, 16'd9, 0));
        add_order(mk_order(KIND_LIMIT, SIDE_BUY, 10'd0, 16'd0, 0));
        add_order(mk_order(KIND_MARKET, SIDE_BUY, 10'd1023, 16'd100, 0));
        add_order(mk_order(KIND_MARKET, SIDE_BUY, 10'd0, 16'h7FFF, 0));
        add_order(mk_order(KIND_MARKET, SIDE_SELL, 10'd0, 16'hFFFF, 0));
        add_order(mk_order(KIND_MARKET, SIDE_BUY, 10'd0, 16'hFFFF, 0));
        add_order(mk_order(KIND_MARKET, SIDE_SELL, 10'd0, 16'd3, 0));

        // Random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++)
            for (int i = 0; i < 108; i++)
                add_order(rand_order(phase_idle[ph]));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: stimulus taken, no result outstanding, then a short tail
        while (pending_orders.size() > 0 || start || expected_fills.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("ran %0d limit and %0d market orders, %0d results, %0d store-full rejects",
                 n_limits, n_markets, n_fills, n_rejects);
        if (n_mismatch == 0 && expected_fills.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches", n_mismatch);
            $display("FAIL");
        end
        $finish;
    end

endmodule
